[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// clocked property checks shared by the rtl, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[sv/urcb_pkg.sv]
// ---------------------------------------------------------------------------
// urcb_pkg
// types, sizes and codes of the undo/redo character buffer
// ---------------------------------------------------------------------------
package urcb_pkg;

  localparam int TEXT_DEPTH  = 1024;
  localparam int STACK_DEPTH = 128;
  localparam int TEXT_AW     = $clog2(TEXT_DEPTH);
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int LEN_W       = 11;
  localparam int LVL_W       = 8;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_UNDO   = 2'd1;
  localparam logic [1:0] REQ_REDO   = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_UNDO = 2'd1;
  localparam logic [1:0] ST_NO_REDO = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] new_char;
    logic [9:0] read_pos;
  } urcb_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       read_char;
    logic [LEN_W-1:0] text_length;
    logic [LVL_W-1:0] undo_count;
    logic [LVL_W-1:0] redo_count;
  } urcb_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } urcb_state_t;

endpackage

[sv/undo_redo_char_buffer_top.sv]
// ---------------------------------------------------------------------------
// undo_redo_char_buffer_top
// character text buffer with an undo stack and a redo stack
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. In the transfer
// cycle of a request the single read of each of the synchronous text, undo
// and redo memories is issued, and the following cycle (busy high) does the
// write-back and registers the response. The response is on rsp for one
// cycle with done high, in the cycle after busy drops, and must be taken
// then; a new request may be started in that same cycle, but none is taken
// while busy is high. Counts in the response are those after the request.
// An insert into a full text or a redo into a full text returns status full
// and leaves all state unchanged.
`include "assert_macros.svh"

module undo_redo_char_buffer_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  urcb_pkg::urcb_req_t req,
  output logic                done,
  output urcb_pkg::urcb_rsp_t rsp
);
  import urcb_pkg::*;

  urcb_state_t state;
  urcb_req_t   req_q;
  logic        accept;

  logic [LEN_W-1:0] text_len, text_len_next;
  logic [LVL_W-1:0] undo_level, undo_level_next;
  logic [LVL_W-1:0] redo_level, redo_level_next;

  logic [7:0] text_mem [TEXT_DEPTH];
  logic [7:0] undo_mem [STACK_DEPTH];
  logic [7:0] redo_mem [STACK_DEPTH];
  logic [7:0] text_rdata, undo_rdata, redo_rdata;

  logic       text_we, undo_we, redo_we;
  logic [7:0] text_wdata, undo_wdata;
  urcb_rsp_t  rsp_next;

  assign busy   = (state == S_EXEC);
  assign accept = start && !busy;

  // memories: read issued on the request transfer, written in the exec cycle
  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[text_len[TEXT_AW-1:0]] <= text_wdata;
    end
    if (accept) begin
      text_rdata <= text_mem[req.read_pos[TEXT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (undo_we) begin
      undo_mem[undo_level[STACK_AW-1:0]] <= undo_wdata;
    end
    if (accept) begin
      undo_rdata <= undo_mem[undo_level[STACK_AW-1:0] - STACK_AW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (redo_we) begin
      redo_mem[redo_level[STACK_AW-1:0]] <= undo_rdata;
    end
    if (accept) begin
      redo_rdata <= redo_mem[redo_level[STACK_AW-1:0] - STACK_AW'(1)];
    end
  end

  // exec cycle: update counts, pick memory writes and build the response
  always_comb begin
    text_len_next   = text_len;
    undo_level_next = undo_level;
    redo_level_next = redo_level;
    text_we         = 1'b0;
    undo_we         = 1'b0;
    redo_we         = 1'b0;
    text_wdata      = req_q.new_char;
    undo_wdata      = req_q.new_char;
    rsp_next        = '0;
    if (busy) begin
      case (req_q.req_type)
        REQ_INSERT: begin
          if (text_len >= LEN_W'(TEXT_DEPTH)) begin
            rsp_next.status = ST_FULL;
          end else begin
            text_we         = 1'b1;
            text_len_next   = text_len + LEN_W'(1);
            redo_level_next = '0;
            if (undo_level < LVL_W'(STACK_DEPTH)) begin
              undo_we         = 1'b1;
              undo_level_next = undo_level + LVL_W'(1);
            end
          end
        end
        REQ_UNDO: begin
          if (undo_level == '0) begin
            rsp_next.status = ST_NO_UNDO;
          end else begin
            undo_level_next = undo_level - LVL_W'(1);
            if (text_len != '0) begin
              text_len_next = text_len - LEN_W'(1);
              if (redo_level < LVL_W'(STACK_DEPTH)) begin
                redo_we         = 1'b1;
                redo_level_next = redo_level + LVL_W'(1);
              end
            end
          end
        end
        REQ_REDO: begin
          if (redo_level == '0) begin
            rsp_next.status = ST_NO_REDO;
          end else if (text_len >= LEN_W'(TEXT_DEPTH)) begin
            rsp_next.status = ST_FULL;
          end else begin
            redo_level_next = redo_level - LVL_W'(1);
            text_we         = 1'b1;
            text_wdata      = redo_rdata;
            undo_wdata      = redo_rdata;
            text_len_next   = text_len + LEN_W'(1);
            if (undo_level < LVL_W'(STACK_DEPTH)) begin
              undo_we         = 1'b1;
              undo_level_next = undo_level + LVL_W'(1);
            end
          end
        end
        REQ_READ: begin
          if (LEN_W'(req_q.read_pos) < text_len) begin
            rsp_next.read_char = text_rdata;
          end
        end
        default: begin
          rsp_next.status = ST_OK;
        end
      endcase
    end
    rsp_next.text_length = text_len_next;
    rsp_next.undo_count  = undo_level_next;
    rsp_next.redo_count  = redo_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      text_len   <= '0;
      undo_level <= '0;
      redo_level <= '0;
    end else begin
      done       <= busy;
      text_len   <= text_len_next;
      undo_level <= undo_level_next;
      redo_level <= redo_level_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (busy) begin
      rsp <= rsp_next;
    end
  end

  `ASSERT_NEXT(a_accept_exec, clk, rst, accept, busy, "request transfer did not enter exec")
  `ASSERT_NEXT(a_exec_done, clk, rst, busy, done && !busy, "exec cycle gave no response")
  `ASSERT_SAME(a_undo_bound, clk, rst, 1'b1, undo_level <= LVL_W'(STACK_DEPTH), "undo overflow")
  `ASSERT_SAME(a_redo_bound, clk, rst, 1'b1, redo_level <= LVL_W'(STACK_DEPTH), "redo overflow")

endmodule
